/* sv/lpbr_pkg.sv */
`default_nettype none

package lpbr_pkg;

    // Header length in bytes, default for the top level parameter
    localparam int HEADER_BYTES_DEF = 4;

    // Register reset values
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10;
    localparam logic [30:0] MAX_LENGTH_RST    = 31'd65536;

    // Register indexes (word address bit 2)
    localparam logic REG_TIMEOUT_TICKS = 1'b0;
    localparam logic REG_MAX_LENGTH    = 1'b1;

    // Frame phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_HEADER   = 3'd1,
        ST_DONE     = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_REJECTED = 3'd4,
        ST_FOREIGN  = 3'd5
    } status_t;

    // Input word kinds
    localparam logic KIND_BIT  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

endpackage

`default_nettype wire

/* sv/length_prefixed_bit_receiver_unit.sv */
// Length-prefixed bit receiver. Each input word carries either one received
// bit (tuser = 0) with its sender id, or one timeout tick (tuser = 1); every
// input word yields exactly one result word. The first bit of a frame locks
// its sender (sender 0 never locks) and bits from other senders get status 5.
// Bits arrive MSB first; the first HEADER_BYTES bytes form a little-endian
// 32-bit length (bytes past the fourth are ignored), then the payload bytes
// are emitted as they complete, the final one with tlast. A zero length ends
// the frame at the header; a negative length or one above max_length is
// rejected. timeout_ticks ticks in a row without an accepted bit abort an
// open frame. Throughput is one word per clock: the frame state is updated
// and the result registered in the cycle the word is accepted, and an input
// word is taken whenever the output register is empty or being drained in
// the same cycle.
`default_nettype none

module length_prefixed_bit_receiver_unit #(
    parameter int HEADER_BYTES = lpbr_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [21:0] sender, [22] bit_value, [23] zero
    input  wire logic        s_tuser,   // [0] kind
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [0] ack_valid, [22:1] ack_target,
                                        // [23] byte_valid, [31:24] data_byte,
                                        // [32] length_valid, [64:33] message_length,
                                        // [71:65] zero
    output logic [2:0]       m_tuser,   // [2:0] status
    output logic             m_tlast,   // last_byte
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [15:0] timeout_ticks_reg;
    logic [30:0] max_length_reg;

    // Frame state
    lpbr_pkg::phase_t phase_reg, phase_next;
    logic [21:0] locked_sender_reg, locked_sender_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [30:0] byte_count_reg, byte_count_next;
    logic [31:0] length_word_reg, length_word_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;

    // Result register
    logic        out_valid_reg;
    logic [71:0] out_data_reg;
    lpbr_pkg::status_t out_status_reg;
    logic        out_last_reg;

    // Result fields of the current word
    logic              res_ack;
    logic [21:0]       res_target;
    logic              res_byte_valid;
    logic [7:0]        res_byte;
    logic              res_last;
    logic              res_len_valid;
    logic [31:0]       res_len;
    lpbr_pkg::status_t res_status;

    logic        in_kind;
    logic [21:0] in_sender;
    logic        in_bit;
    logic        in_accept;
    logic [7:0]  full_byte;
    logic [30:0] byte_count_inc;
    logic [15:0] idle_ticks_inc;

    assign in_kind   = s_tuser;
    assign in_sender = s_tdata[21:0];
    assign in_bit    = s_tdata[22];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign full_byte      = {shift_byte_reg[6:0], in_bit};
    assign byte_count_inc = byte_count_reg + 31'd1;
    assign idle_ticks_inc = idle_ticks_reg + 16'd1;

    // APB register file
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lpbr_pkg::REG_MAX_LENGTH) ? {1'b0, max_length_reg}
                                                           : {16'd0, timeout_ticks_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= lpbr_pkg::TIMEOUT_TICKS_RST;
            max_length_reg    <= lpbr_pkg::MAX_LENGTH_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == lpbr_pkg::REG_MAX_LENGTH)
                max_length_reg <= pwdata[30:0];
            else
                timeout_ticks_reg <= pwdata[15:0];
        end
    end

    // Frame state update and result for one word
    always_comb
    begin
        phase_next         = phase_reg;
        locked_sender_next = locked_sender_reg;
        shift_byte_next    = shift_byte_reg;
        bit_count_next     = bit_count_reg;
        byte_count_next    = byte_count_reg;
        length_word_next   = length_word_reg;
        idle_ticks_next    = idle_ticks_reg;

        res_ack        = 1'b0;
        res_target     = '0;
        res_byte_valid = 1'b0;
        res_byte       = '0;
        res_last       = 1'b0;
        res_len_valid  = 1'b0;
        res_len        = '0;
        res_status     = lpbr_pkg::ST_NONE;

        if (in_kind == lpbr_pkg::KIND_TICK)
        begin
            // silence counter, only while a frame is open
            if (phase_reg != lpbr_pkg::PH_IDLE)
            begin
                idle_ticks_next = idle_ticks_inc;
                if (idle_ticks_inc >= timeout_ticks_reg || idle_ticks_inc == 16'd0)
                    res_status = lpbr_pkg::ST_TIMEOUT;
            end
        end
        else if (locked_sender_reg != 22'd0 && in_sender != locked_sender_reg)
        begin
            res_status = lpbr_pkg::ST_FOREIGN;
        end
        else
        begin
            // idle state is already cleared; just open the frame
            if (phase_reg == lpbr_pkg::PH_IDLE)
            begin
                phase_next         = lpbr_pkg::PH_HEADER;
                locked_sender_next = in_sender;
            end
            res_ack         = 1'b1;
            res_target      = in_sender;
            idle_ticks_next = '0;
            shift_byte_next = full_byte;
            bit_count_next  = bit_count_reg + 3'd1;

            if (bit_count_reg == 3'd7)
            begin
                shift_byte_next = '0;
                if (phase_reg != lpbr_pkg::PH_PAYLOAD)
                begin
                    // header byte, little-endian into the length word
                    if (byte_count_reg < 31'd4)
                        length_word_next[{byte_count_reg[1:0], 3'b000} +: 8] =
                            length_word_reg[{byte_count_reg[1:0], 3'b000} +: 8] | full_byte;
                    byte_count_next = byte_count_inc;
                    if (byte_count_inc >= 31'(HEADER_BYTES))
                    begin
                        res_len_valid = 1'b1;
                        res_len       = length_word_next;
                        if (length_word_next == 32'd0)
                            res_status = lpbr_pkg::ST_HEADER;
                        else if (length_word_next[31] ||
                                 length_word_next[30:0] > max_length_reg)
                            res_status = lpbr_pkg::ST_REJECTED;
                        else
                        begin
                            res_status      = lpbr_pkg::ST_HEADER;
                            phase_next      = lpbr_pkg::PH_PAYLOAD;
                            byte_count_next = '0;
                        end
                    end
                end
                else
                begin
                    // payload byte
                    res_byte_valid  = 1'b1;
                    res_byte        = full_byte;
                    byte_count_next = byte_count_inc;
                    if ({1'b0, byte_count_inc} >= length_word_reg)
                    begin
                        res_last   = 1'b1;
                        res_status = lpbr_pkg::ST_DONE;
                    end
                end
            end
        end

        // any frame end returns to a cleared idle state
        if (res_status == lpbr_pkg::ST_TIMEOUT || res_status == lpbr_pkg::ST_DONE ||
            res_status == lpbr_pkg::ST_REJECTED ||
            (res_status == lpbr_pkg::ST_HEADER && phase_next != lpbr_pkg::PH_PAYLOAD))
        begin
            phase_next         = lpbr_pkg::PH_IDLE;
            locked_sender_next = '0;
            shift_byte_next    = '0;
            bit_count_next     = '0;
            byte_count_next    = '0;
            length_word_next   = '0;
            idle_ticks_next    = '0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= lpbr_pkg::PH_IDLE;
            locked_sender_reg <= '0;
            shift_byte_reg    <= '0;
            bit_count_reg     <= '0;
            byte_count_reg    <= '0;
            length_word_reg   <= '0;
            idle_ticks_reg    <= '0;
        end
        else if (in_accept)
        begin
            phase_reg         <= phase_next;
            locked_sender_reg <= locked_sender_next;
            shift_byte_reg    <= shift_byte_next;
            bit_count_reg     <= bit_count_next;
            byte_count_reg    <= byte_count_next;
            length_word_reg   <= length_word_next;
            idle_ticks_reg    <= idle_ticks_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg   <= {7'd0, res_len, res_len_valid, res_byte, res_byte_valid,
                               res_target, res_ack};
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lpbr_pkg::PH_IDLE) |->
            (locked_sender_reg == 22'd0 && bit_count_reg == 3'd0 &&
             byte_count_reg == 31'd0 && length_word_reg == 32'd0))
        else $error("idle with stale frame state");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_last) |=> (phase_reg == lpbr_pkg::PH_IDLE))
        else $error("frame still open after last byte");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == lpbr_pkg::ST_DONE) |-> out_last_reg)
        else $error("message done without last byte");

endmodule

`default_nettype wire
